// File: rtl/core/grid_minimax_path_effort_assert.svh
// Assertion macros for the grid minimax path effort block.
`ifndef GRID_MINIMAX_PATH_EFFORT_ASSERT_SVH
`define GRID_MINIMAX_PATH_EFFORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GMPE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid_minimax_path_effort: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GMPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid_minimax_path_effort: next-cycle check failed");

`endif

// File: rtl/core/gmpe_pkg.sv
// Shared types and constants of the grid minimax path effort block.
`default_nettype none
package gmpe_pkg;

  localparam int IN_HEIGHT_W  = 20;
  localparam int OUT_EFFORT_W = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESULT_RD,
    ST_RESULT
  } gmpe_state_t;

endpackage
`default_nettype wire

// File: rtl/core/gmpe_ifs.sv
// Handshake channel interfaces: height input, result output, configuration write.
`default_nettype none
interface gmpe_in_if import gmpe_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [IN_HEIGHT_W-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface gmpe_out_if import gmpe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OUT_EFFORT_W-1:0] min_effort;
  logic                    heap_overflow;
  modport source (output valid, output min_effort, output heap_overflow, input ready);
  modport sink (input valid, input min_effort, input heap_overflow, output ready);
endinterface

interface gmpe_cfg_if import gmpe_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/gmpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/core/gmpe_cell.sv
// One stage of the sweep delay chain: holds a cell's height and effort.
`default_nettype none
module gmpe_cell #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);
  logic [WIDTH-1:0] q_r;

  // advance only when a swept cell leaves the compute stage
  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

// File: rtl/core/grid_minimax_path_effort.sv
// Top level of the grid minimax path effort block.
`default_nettype none
// Loads grid_rows x grid_cols heights in row-major order, one item per cycle
// into a height RAM, and on the item that completes the grid searches for the
// least bottleneck effort from the top-left to the bottom-right cell. The
// search alternates forward and backward raster sweeps over the grid: each
// swept cell is relaxed against the cell swept just before it (left or
// right) and the one swept a row earlier (up or down), read from a chain of
// MAX_COLS delay cells. Sweeps repeat until one after the first changes
// nothing. Each sweep issues every cell in turn and then passes through the
// drain and decision states, the first sweep stands in for clearing the
// effort store, and the result is read from the store after the last
// sweep. Inputs and configuration writes are not accepted while a search
// runs; a row or column write taken while loading restarts the load.
// heap_overflow is always 0: the sweep keeps no queue, so no entry can be lost.
module grid_minimax_path_effort import gmpe_pkg::*; #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32
) (
  input wire logic    clk,
  input wire logic    rst_n,
  gmpe_in_if.sink     in_ch,
  gmpe_out_if.source  out_ch,
  gmpe_cfg_if.sink    cfg_ch
);
  localparam int HEIGHT_BITS = IN_HEIGHT_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int DRW   = $clog2(MAX_ROWS + 1);
  localparam int DCW   = $clog2(MAX_COLS + 1);
  localparam int BW    = HEIGHT_BITS + 1;
  localparam int LW    = HEIGHT_BITS + BW;
  localparam logic [BW-1:0] EFF_INF = {1'b1, {HEIGHT_BITS{1'b0}}};

  // configuration and clamped dimensions
  logic [CFG_DATA_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [DRW-1:0]        rows_dim;
  logic [DCW-1:0]        cols_dim;
  logic [AW:0]           total;
  logic [AW-1:0]         last_addr;
  logic [RW-1:0]         last_row;
  logic [CW-1:0]         last_col;
  logic                  cfg_wr, cfg_hit;
  logic                  cfg_ready_w;

  // control state
  gmpe_state_t state_r, state_nxt;

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_dim = DRW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      rows_dim = DRW'(MAX_ROWS);
    end else begin
      rows_dim = DRW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_dim = DCW'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      cols_dim = DCW'(MAX_COLS);
    end else begin
      cols_dim = DCW'(cols_cfg_r);
    end
  end

  assign total     = (AW + 1)'(rows_dim) * (AW + 1)'(cols_dim);
  assign last_addr = AW'(total - 1'b1);
  assign last_row  = RW'(rows_dim - 1'b1);
  assign last_col  = CW'(cols_dim - 1'b1);
  // hold configuration off while a search or its result is under way
  assign cfg_ready_w = (state_r == ST_LOAD);
  assign cfg_ch.ready = cfg_ready_w;
  assign cfg_wr  = cfg_ch.valid && cfg_ready_w;
  assign cfg_hit = (cfg_ch.index == REG_GRID_ROWS) || (cfg_ch.index == REG_GRID_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_DATA_W'(1);
      cols_cfg_r <= CFG_DATA_W'(1);
    end else if (cfg_wr) begin
      if (cfg_ch.index == REG_GRID_ROWS) begin
        rows_cfg_r <= cfg_ch.data;
      end
      if (cfg_ch.index == REG_GRID_COLS) begin
        cols_cfg_r <= cfg_ch.data;
      end
    end
  end

  logic [AW:0]   load_cnt_r;
  logic [AW:0]   load_pos;
  logic          in_acc, load_done;
  logic          fwd_r, first_pass_r, changed_r;
  logic [AW-1:0] iss_addr_r;
  logic [RW-1:0] iss_row_r;
  logic [CW-1:0] iss_col_r;
  logic          iss_last;
  logic          s1_vld_r;
  logic [AW-1:0] s1_addr_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          out_vld_r;
  logic [OUT_EFFORT_W-1:0] min_effort_r;
  logic          out_free;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && (state_r == ST_LOAD);
  assign load_pos    = (load_cnt_r >= total) ? '0 : load_cnt_r;
  assign load_done   = ((load_pos + 1'b1) == total);
  assign iss_last    = fwd_r ? (iss_addr_r == last_addr) : (iss_addr_r == '0);
  assign out_free    = !out_vld_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && load_done) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (iss_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!first_pass_r && !changed_r) begin
          state_nxt = ST_RESULT_RD;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_RESULT_RD: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // memory addressing
  logic [AW-1:0]          rd_addr;
  logic [HEIGHT_BITS-1:0] h_rd;
  logic [BW-1:0]          b_rd;
  logic [BW-1:0]          best_new;

  always_comb begin
    case (state_r)
      ST_PASS:      rd_addr = iss_addr_r;
      ST_RESULT_RD: rd_addr = last_addr;
      ST_RESULT:    rd_addr = last_addr;
      default:      rd_addr = iss_addr_r;
    endcase
  end

  gmpe_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_height_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (AW'(load_pos)),
    .wdata (HEIGHT_BITS'(in_ch.height)),
    .raddr (rd_addr),
    .rdata (h_rd)
  );

  gmpe_ram #(.WIDTH(BW), .DEPTH(CELLS)) u_effort_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (best_new),
    .raddr (rd_addr),
    .rdata (b_rd)
  );

  // delay chain: tap 0 is the previous swept cell, tap cols-1 the one a row back
  logic [LW-1:0] chain_q [MAX_COLS];
  logic [LW-1:0] chain_d [MAX_COLS];

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign chain_d[k] = {h_rd, best_new};
    end else begin : g_link
      assign chain_d[k] = chain_q[k-1];
    end
    gmpe_cell #(.WIDTH(LW)) u_cell (
      .clk   (clk),
      .shift (s1_vld_r),
      .d     (chain_d[k]),
      .q     (chain_q[k])
    );
  end

  // relax the swept cell against its two already-swept neighbours
  logic [LW-1:0]          nb_a, nb_b;
  logic                   nb_a_ok, nb_b_ok;
  logic [BW-1:0]          old_best, cand_a, cand_b;
  logic [HEIGHT_BITS-1:0] ha, hb, da, db;

  always_comb begin
    nb_a     = chain_q[0];
    nb_b     = chain_q[last_col];
    ha       = nb_a[LW-1:BW];
    hb       = nb_b[LW-1:BW];
    nb_a_ok  = fwd_r ? (s1_col_r != '0) : (s1_col_r != last_col);
    nb_b_ok  = fwd_r ? (s1_row_r != '0) : (s1_row_r != last_row);
    da       = (h_rd > ha) ? (h_rd - ha) : (ha - h_rd);
    db       = (h_rd > hb) ? (h_rd - hb) : (hb - h_rd);
    cand_a   = (nb_a[BW-1:0] > BW'(da)) ? nb_a[BW-1:0] : BW'(da);
    cand_b   = (nb_b[BW-1:0] > BW'(db)) ? nb_b[BW-1:0] : BW'(db);
    // the first sweep reads no store: every cell but the origin starts at infinity
    if (first_pass_r) begin
      old_best = (s1_addr_r == '0) ? '0 : EFF_INF;
    end else begin
      old_best = b_rd;
    end
    best_new = old_best;
    if (nb_a_ok && (cand_a < best_new)) begin
      best_new = cand_a;
    end
    if (nb_b_ok && (cand_b < best_new)) begin
      best_new = cand_b;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_cnt_r   <= '0;
      fwd_r        <= 1'b1;
      first_pass_r <= 1'b1;
      changed_r    <= 1'b0;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // drop a partial load on a write to the row or column register
      if (cfg_wr && cfg_hit) begin
        load_cnt_r <= '0;
      end else if (in_acc) begin
        load_cnt_r <= load_done ? '0 : load_pos + 1'b1;
      end
      s1_vld_r <= (state_r == ST_PASS);
      if (s1_vld_r && (best_new < old_best)) begin
        changed_r <= 1'b1;
      end
      if (state_r == ST_LOAD && in_acc && load_done) begin
        fwd_r        <= 1'b1;
        first_pass_r <= 1'b1;
        changed_r    <= 1'b0;
      end else if (state_r == ST_DECIDE) begin
        fwd_r        <= !fwd_r;
        first_pass_r <= 1'b0;
        changed_r    <= 1'b0;
      end
      if (state_r == ST_RESULT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // sweep counters and result payload
  always_ff @(posedge clk) begin
    s1_addr_r <= iss_addr_r;
    s1_row_r  <= iss_row_r;
    s1_col_r  <= iss_col_r;
    if ((state_r == ST_LOAD) || (state_r == ST_DECIDE)) begin
      // the sweep after a forward one runs backward, and the first runs forward
      if ((state_r == ST_DECIDE) && fwd_r) begin
        iss_addr_r <= last_addr;
        iss_row_r  <= last_row;
        iss_col_r  <= last_col;
      end else begin
        iss_addr_r <= '0;
        iss_row_r  <= '0;
        iss_col_r  <= '0;
      end
    end else if (state_r == ST_PASS) begin
      if (fwd_r) begin
        iss_addr_r <= iss_addr_r + 1'b1;
        if (iss_col_r == last_col) begin
          iss_col_r <= '0;
          iss_row_r <= iss_row_r + 1'b1;
        end else begin
          iss_col_r <= iss_col_r + 1'b1;
        end
      end else begin
        iss_addr_r <= iss_addr_r - 1'b1;
        if (iss_col_r == '0) begin
          iss_col_r <= last_col;
          iss_row_r <= iss_row_r - 1'b1;
        end else begin
          iss_col_r <= iss_col_r - 1'b1;
        end
      end
    end
    if (state_r == ST_RESULT && out_free) begin
      min_effort_r <= OUT_EFFORT_W'(b_rd[HEIGHT_BITS-1:0]);
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.min_effort    = min_effort_r;
  assign out_ch.heap_overflow = 1'b0;

`include "grid_minimax_path_effort_assert.svh"

  `GMPE_ASSERT_IMPLIES(a_result_from_read, $rose(out_vld_r), $past(state_r) == ST_RESULT)
  `GMPE_ASSERT_IMPLIES(a_write_in_sweep, s1_vld_r, (state_r == ST_PASS) || (state_r == ST_DRAIN))
  `GMPE_ASSERT_IMPLIES(a_origin_zero, s1_vld_r && (s1_addr_r == '0), best_new == '0)
  `GMPE_ASSERT_NEXT(a_sweep_drains, (state_r == ST_PASS) && iss_last, state_r == ST_DRAIN)

endmodule
`default_nettype wire
